[rtl/core/fps_pkg.sv]
package fps_pkg;

  localparam int FRAME_BITS       = 20;
  localparam int COUNT_BITS       = 14;
  localparam int SPEED_BITS       = 5;
  localparam int NUM_SPEEDS       = 17;
  localparam int TICKS_PER_SECOND = 1000;
  localparam int RESET_SPEED      = 10;
  localparam int FCOUNT_BITS      = FRAME_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX      = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] RESET_INTERVAL = COUNT_BITS'(TICKS_PER_SECOND);
  localparam logic [SPEED_BITS-1:0] SPEED_RESET    = SPEED_BITS'(RESET_SPEED);
  localparam logic [SPEED_BITS-1:0] SPEED_LAST     = SPEED_BITS'(NUM_SPEEDS - 1);

  typedef enum logic [3:0] {
    MODE_TICK      = 4'd0,
    MODE_PLAY_FWD  = 4'd1,
    MODE_PLAY_REV  = 4'd2,
    MODE_STOP      = 4'd3,
    MODE_NEXT      = 4'd4,
    MODE_PREV      = 4'd5,
    MODE_SET_FRAME = 4'd6,
    MODE_FASTER    = 4'd7,
    MODE_SLOWER    = 4'd8,
    MODE_SET_SPEED = 4'd9
  } mode_t;

  typedef struct packed {
    logic [3:0]            mode;
    logic [FRAME_BITS-1:0] frame_value;
    logic [SPEED_BITS-1:0] speed_value;
  } item_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  frame_event;
    logic                  running;
    logic [SPEED_BITS-1:0] speed_index;
    logic                  reverse_flag;
  } result_t;

  // Tick interval in ms per speed step: 1000/fps, truncated.
  function automatic logic [COUNT_BITS-1:0] speed_interval(input logic [SPEED_BITS-1:0] idx);
    logic [COUNT_BITS-1:0] iv;
    unique case (idx)
      5'd0:    iv = 14'd15000;
      5'd1:    iv = 14'd10000;
      5'd2:    iv = 14'd5000;
      5'd3:    iv = 14'd4000;
      5'd4:    iv = 14'd3000;
      5'd5:    iv = 14'd2000;
      5'd6:    iv = 14'd1000;
      5'd7:    iv = 14'd500;
      5'd8:    iv = 14'd333;
      5'd9:    iv = 14'd250;
      5'd10:   iv = 14'd200;
      5'd11:   iv = 14'd100;
      5'd12:   iv = 14'd66;
      5'd13:   iv = 14'd50;
      5'd14:   iv = 14'd40;
      5'd15:   iv = 14'd33;
      default: iv = 14'd16;
    endcase
    return iv;
  endfunction

endpackage

[rtl/core/fps_if.sv]
interface fps_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [3:0]                    mode;
  logic [fps_pkg::FRAME_BITS-1:0] frame_value;
  logic [fps_pkg::SPEED_BITS-1:0] speed_value;
  modport source (output valid, mode, frame_value, speed_value, input ready);
  modport sink (input valid, mode, frame_value, speed_value, output ready);
endinterface

interface fps_res_if;
  logic                          valid;
  logic                          ready;
  logic [fps_pkg::FRAME_BITS-1:0] frame;
  logic                          frame_event;
  logic                          running;
  logic [fps_pkg::SPEED_BITS-1:0] speed_index;
  logic                          reverse_flag;
  modport source (output valid, frame, frame_event, running, speed_index, reverse_flag,
                  input ready);
  modport sink (input valid, frame, frame_event, running, speed_index, reverse_flag,
                output ready);
endinterface

interface fps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fps_pkg::FCOUNT_BITS-1:0] frame_count;
  modport source (output valid, frame_count, input ready);
  modport sink (input valid, frame_count, output ready);
endinterface

[rtl/core/frame_playback_sequencer.sv]
// Frame playback sequencer: one request (command or 1 ms tick) per cycle
// while results are taken. A request loads the input register at the accept,
// and the state update loads the result register once that register is free.
// Throughput: 1 request per cycle unless res.ready stalls the result register.
// Reset (rst, synchronous): stopped, forward, frame 0, speed index 10,
// interval 1000 ms, one-frame sequence, no pending request or result.
module frame_playback_sequencer (
  input logic    clk,
  input logic    rst,
  fps_cmd_if.sink   cmd,
  fps_res_if.source res,
  fps_cfg_if.sink   cfg
);
  import fps_pkg::*;

  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    advance;
  logic    res_valid;
  result_t res_data;

  // Pack the incoming request.
  assign in_item.mode        = cmd.mode;
  assign in_item.frame_value = cmd.frame_value;
  assign in_item.speed_value = cmd.speed_value;

  // The held request moves into the result register whenever that register
  // is empty or being drained this cycle, so the pipe never bubbles.
  assign advance = q_valid && (!res_valid || res.ready);

  fps_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .in_item  (in_item),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // Config writes are always taken; the user must change the sequence length
  // only while the block is idle, which the block itself does not enforce.
  assign cfg.ready = 1'b1;

  fps_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .item            (q_item),
    .cfg_we          (cfg.valid),
    .cfg_frame_count (cfg.frame_count),
    .res_ready       (res.ready),
    .res_valid       (res_valid),
    .res_data        (res_data)
  );

  assign res.valid        = res_valid;
  assign res.frame        = res_data.frame;
  assign res.frame_event  = res_data.frame_event;
  assign res.running      = res_data.running;
  assign res.speed_index  = res_data.speed_index;
  assign res.reverse_flag = res_data.reverse_flag;

endmodule

[rtl/core/fps_in_stage.sv]
module fps_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fps_pkg::item_t in_item,
  input  logic           advance,
  output logic           q_valid,
  output fps_pkg::item_t q_item
);
  import fps_pkg::*;

  logic take;

  assign in_ready = !q_valid || advance;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (take) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_item <= in_item;
    end
  end

endmodule

[rtl/core/fps_engine.sv]
module fps_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  fps_pkg::item_t                  item,
  input  logic                            cfg_we,
  input  logic [fps_pkg::FCOUNT_BITS-1:0] cfg_frame_count,
  input  logic                            res_ready,
  output logic                            res_valid,
  output fps_pkg::result_t                res_data
);
  import fps_pkg::*;

  logic [FRAME_BITS-1:0] frame_now, frame_now_next;
  logic [FRAME_BITS-1:0] last_frame, last_frame_next;
  logic                  reverse_dir, reverse_dir_next;
  logic                  active, active_next;
  logic [SPEED_BITS-1:0] speed_sel, speed_sel_next;
  logic [COUNT_BITS-1:0] tick_interval, tick_interval_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic                  event_flag;
  logic [FRAME_BITS-1:0] frame_fwd, frame_bwd;
  logic [COUNT_BITS-1:0] count_inc;
  logic [SPEED_BITS-1:0] speed_up, speed_dn;
  logic [FCOUNT_BITS-1:0] fc_minus;
  mode_t                 mode;

  // Last frame: zero count acts as one frame, oversize count saturates.
  assign fc_minus = cfg_frame_count - FCOUNT_BITS'(1);
  always_comb begin
    if (cfg_frame_count == '0) begin
      last_frame_next = '0;
    end else if (fc_minus[FRAME_BITS]) begin
      last_frame_next = '1;
    end else begin
      last_frame_next = fc_minus[FRAME_BITS-1:0];
    end
  end

  assign frame_fwd = (frame_now >= last_frame) ? '0 : frame_now + FRAME_BITS'(1);
  assign frame_bwd = (frame_now == '0) ? last_frame : frame_now - FRAME_BITS'(1);
  assign count_inc = (tick_count != COUNT_MAX) ? tick_count + COUNT_BITS'(1) : tick_count;
  assign speed_up  = speed_sel + SPEED_BITS'(1);
  assign speed_dn  = speed_sel - SPEED_BITS'(1);
  assign mode      = mode_t'(item.mode);

  always_comb begin
    frame_now_next     = frame_now;
    reverse_dir_next   = reverse_dir;
    active_next        = active;
    speed_sel_next     = speed_sel;
    tick_interval_next = tick_interval;
    tick_count_next    = tick_count;
    event_flag         = 1'b0;
    unique case (mode)
      MODE_TICK: begin
        if (active) begin
          if (count_inc >= tick_interval) begin
            tick_count_next = '0;
            frame_now_next  = reverse_dir ? frame_bwd : frame_fwd;
            event_flag      = 1'b1;
          end else begin
            tick_count_next = count_inc;
          end
        end
      end
      MODE_PLAY_FWD, MODE_PLAY_REV: begin
        reverse_dir_next = (mode == MODE_PLAY_REV);
        active_next      = 1'b1;
        tick_count_next  = '0;
        event_flag       = 1'b1;
      end
      MODE_STOP: begin
        active_next = 1'b0;
      end
      MODE_NEXT: begin
        active_next    = 1'b0;
        frame_now_next = frame_fwd;
        event_flag     = 1'b1;
      end
      MODE_PREV: begin
        active_next    = 1'b0;
        frame_now_next = frame_bwd;
        event_flag     = 1'b1;
      end
      MODE_SET_FRAME: begin
        if (item.frame_value != frame_now) begin
          frame_now_next = (item.frame_value > last_frame) ? '0 : item.frame_value;
          event_flag     = 1'b1;
        end
      end
      MODE_FASTER: begin
        if (speed_sel < SPEED_LAST) begin
          speed_sel_next     = speed_up;
          tick_interval_next = speed_interval(speed_up);
          tick_count_next    = '0;
          active_next        = 1'b1;
        end
      end
      MODE_SLOWER: begin
        if (speed_sel != '0) begin
          speed_sel_next     = speed_dn;
          tick_interval_next = speed_interval(speed_dn);
          tick_count_next    = '0;
          active_next        = 1'b1;
        end
      end
      MODE_SET_SPEED: begin
        if (item.speed_value <= SPEED_LAST) begin
          speed_sel_next     = item.speed_value;
          tick_interval_next = speed_interval(item.speed_value);
          tick_count_next    = '0;
          active_next        = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_now     <= '0;
      last_frame    <= '0;
      reverse_dir   <= 1'b0;
      active        <= 1'b0;
      speed_sel     <= SPEED_RESET;
      tick_interval <= RESET_INTERVAL;
      tick_count    <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (advance) begin
        frame_now     <= frame_now_next;
        reverse_dir   <= reverse_dir_next;
        active        <= active_next;
        speed_sel     <= speed_sel_next;
        tick_interval <= tick_interval_next;
        tick_count    <= tick_count_next;
      end
      if (cfg_we) begin
        last_frame <= last_frame_next;
        frame_now  <= '0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data.frame        <= frame_now_next;
      res_data.frame_event  <= event_flag;
      res_data.running      <= active_next;
      res_data.speed_index  <= speed_sel_next;
      res_data.reverse_flag <= reverse_dir_next;
    end
  end

endmodule

[verif/frame_playback_sequencer_checker.sv]
`timescale 1ns / 100ps

module frame_playback_sequencer_checker
  import fps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  fps_cmd_if   cmd,
  fps_res_if   res,
  fps_cfg_if   cfg,
  output int   fail_count,
  output int   results_seen,
  output int   events_seen,
  output int   backlog
);

  // Shadow playback state
  logic [FCOUNT_BITS-1:0] seq_len;
  logic [FRAME_BITS-1:0]  cur_frame;
  logic                   backward;
  logic                   playing;
  logic [SPEED_BITS-1:0]  speed_sel;
  logic [COUNT_BITS-1:0]  period;
  logic [COUNT_BITS-1:0]  elapsed;

  result_t status_q[$];
  result_t want;
  int      bad;

  // Interval from the rate as a fraction num/den fps: 1000*den/num, truncated.
  function automatic logic [COUNT_BITS-1:0] period_ms(input logic [SPEED_BITS-1:0] idx);
    int fps_num;
    int fps_den;
    fps_num = 1;
    fps_den = 1;
    case (idx)
      0:  fps_den = 15;
      1:  fps_den = 10;
      2:  fps_den = 5;
      3:  fps_den = 4;
      4:  fps_den = 3;
      5:  fps_den = 2;
      6:  fps_num = 1;
      7:  fps_num = 2;
      8:  fps_num = 3;
      9:  fps_num = 4;
      10: fps_num = 5;
      11: fps_num = 10;
      12: fps_num = 15;
      13: fps_num = 20;
      14: fps_num = 25;
      15: fps_num = 30;
      default: fps_num = 60;
    endcase
    return COUNT_BITS'(TICKS_PER_SECOND * fps_den / fps_num);
  endfunction

  // Last frame; zero length acts as one frame, oversize saturates.
  function automatic logic [FRAME_BITS-1:0] wrap_frame();
    if (seq_len == '0) return '0;
    if (seq_len > (FCOUNT_BITS'(1) << FRAME_BITS)) return '1;
    return FRAME_BITS'(seq_len - 1'b1);
  endfunction

  function automatic void step_frame(input logic back);
    if (back) begin
      cur_frame = (cur_frame == '0) ? wrap_frame() : cur_frame - 1'b1;
    end else begin
      cur_frame = (cur_frame >= wrap_frame()) ? '0 : cur_frame + 1'b1;
    end
  endfunction

  function automatic void pick_speed(input logic [SPEED_BITS-1:0] idx);
    speed_sel = idx;
    period    = period_ms(idx);
    elapsed   = '0;
  endfunction

  function automatic result_t apply_request(input logic [3:0] m,
                                            input logic [FRAME_BITS-1:0] fv,
                                            input logic [SPEED_BITS-1:0] sv);
    result_t r;
    logic    hit;
    hit = 1'b0;
    case (m)
      MODE_TICK: begin
        if (playing) begin
          if (elapsed < COUNT_MAX) elapsed = elapsed + 1'b1;
          if (elapsed >= period) begin
            elapsed = '0;
            step_frame(backward);
            hit = 1'b1;
          end
        end
      end
      MODE_PLAY_FWD, MODE_PLAY_REV: begin
        backward = (m == MODE_PLAY_REV);
        playing  = 1'b1;
        elapsed  = '0;
        hit      = 1'b1;
      end
      MODE_STOP: playing = 1'b0;
      MODE_NEXT: begin
        playing = 1'b0;
        step_frame(1'b0);
        hit = 1'b1;
      end
      MODE_PREV: begin
        playing = 1'b0;
        step_frame(1'b1);
        hit = 1'b1;
      end
      MODE_SET_FRAME: begin
        if (fv != cur_frame) begin
          cur_frame = (fv > wrap_frame()) ? '0 : fv;
          hit = 1'b1;
        end
      end
      MODE_FASTER: begin
        if (speed_sel < SPEED_LAST) begin
          pick_speed(speed_sel + 1'b1);
          playing = 1'b1;
        end
      end
      MODE_SLOWER: begin
        if (speed_sel != '0) begin
          pick_speed(speed_sel - 1'b1);
          playing = 1'b1;
        end
      end
      MODE_SET_SPEED: begin
        if (sv <= SPEED_LAST) begin
          pick_speed(sv);
          playing = 1'b0;
        end
      end
      default: ;
    endcase
    r.frame        = cur_frame;
    r.frame_event  = hit;
    r.running      = playing;
    r.speed_index  = speed_sel;
    r.reverse_flag = backward;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      seq_len   = FCOUNT_BITS'(1);
      cur_frame = '0;
      backward  = 1'b0;
      playing   = 1'b0;
      speed_sel = SPEED_RESET;
      period    = RESET_INTERVAL;
      elapsed   = '0;
      status_q.delete();
      fail_count   <= 0;
      results_seen <= 0;
      events_seen  <= 0;
      backlog      <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        seq_len   = cfg.frame_count;
        cur_frame = '0;
      end
      if (cmd.valid && cmd.ready)
        status_q.push_back(apply_request(cmd.mode, cmd.frame_value, cmd.speed_value));
      if (res.valid && res.ready) begin
        results_seen <= results_seen + 1;
        if (res.frame_event === 1'b1) events_seen <= events_seen + 1;
        if (status_q.size() == 0) begin
          $error("result with no request outstanding: frame %0d", res.frame);
          fail_count <= fail_count + 1;
        end else begin
          want = status_q.pop_front();
          bad  = 0;
          if (res.frame !== want.frame) begin
            $error("frame: expected %0d, got %0d", want.frame, res.frame);
            bad++;
          end
          if (res.frame_event !== want.frame_event) begin
            $error("frame_event: expected %0d, got %0d", want.frame_event, res.frame_event);
            bad++;
          end
          if (res.running !== want.running) begin
            $error("running: expected %0d, got %0d", want.running, res.running);
            bad++;
          end
          if (res.speed_index !== want.speed_index) begin
            $error("speed_index: expected %0d, got %0d", want.speed_index, res.speed_index);
            bad++;
          end
          if (res.reverse_flag !== want.reverse_flag) begin
            $error("reverse_flag: expected %0d, got %0d", want.reverse_flag,
                   res.reverse_flag);
            bad++;
          end
          fail_count <= fail_count + bad;
        end
      end
      backlog <= status_q.size();
    end
  end

endmodule

[verif/frame_playback_sequencer_test.sv]
`timescale 1ns / 100ps

module frame_playback_sequencer_test;
  import fps_pkg::*;

  // Run bounds for the watchdog, idle gaps, random phases and final drain.
  localparam int LIMIT_CYCLES     = 600000;
  localparam int MAX_IDLE         = 17;
  localparam int RANDOM_PER_PHASE = 80;
  localparam int NUM_PHASES       = 8;
  localparam int DRAIN_CYCLES     = 8;

  // Mode codes the block has no command for; it must leave state alone.
  localparam logic [3:0] SPARE_MODE_LO = MODE_SET_SPEED + 4'd1;
  localparam logic [3:0] SPARE_MODE_HI = 4'hF;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  fps_cmd_if cmd_if();
  fps_res_if res_if();
  fps_cfg_if cfg_if();

  int fail_count;
  int results_seen;
  int events_seen;
  int backlog;

  frame_playback_sequencer i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  frame_playback_sequencer_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd_if),
    .res          (res_if),
    .cfg          (cfg_if),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .events_seen  (events_seen),
    .backlog      (backlog)
  );

  // Stimulus-side bookkeeping (no prediction here)
  int                    sent;       // every request accepted
  int                    counted;    // accepted requests with a real command
  int                    cfg_writes;
  bit                    idle_on;    // request side inserts gaps
  logic [FRAME_BITS-1:0] span_last;  // last frame of the current sequence

  // One request: optional idle gap, then hold valid until ready.
  // valid is only lowered when a gap is drawn, so back-to-back requests
  // never see a low/high pair in the same step.
  task automatic push_req(input logic [3:0] m, input logic [FRAME_BITS-1:0] fv,
                          input logic [SPEED_BITS-1:0] sv);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.mode        <= m;
    cmd_if.frame_value <= fv;
    cmd_if.speed_value <= sv;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    sent++;
    if (m <= MODE_SET_SPEED) counted++;
  endtask

  // Command whose payload fields are don't-care: fill them with noise.
  task automatic cmd_op(input logic [3:0] m);
    push_req(m, FRAME_BITS'($urandom), SPEED_BITS'($urandom));
  endtask

  task automatic set_frame(input logic [FRAME_BITS-1:0] fv);
    push_req(MODE_SET_FRAME, fv, SPEED_BITS'($urandom));
  endtask

  task automatic set_speed(input logic [SPEED_BITS-1:0] sv);
    push_req(MODE_SET_SPEED, FRAME_BITS'($urandom), sv);
  endtask

  // frame_count may only change with the pipe empty: drain all results,
  // let the block settle, then do the write handshake.
  task automatic load_frame_count(input logic [FCOUNT_BITS-1:0] fc);
    cmd_if.valid <= 1'b0;
    while (results_seen < sent) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.frame_count <= fc;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (fc == '0) span_last = '0;
    else if (fc > (FCOUNT_BITS'(1) << FRAME_BITS)) span_last = '1;
    else span_last = FRAME_BITS'(fc - 1'b1);
    cfg_writes++;
  endtask

  // Frame targets weighted toward the wrap points and the range edges.
  function automatic logic [FRAME_BITS-1:0] pick_frame();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return span_last;
      2: return span_last - 1'b1;
      3: return '1;
      4: return span_last + 1'b1;
      5: return FRAME_BITS'($urandom_range(0, span_last));
      6: return FRAME_BITS'($urandom_range(0, 7));
      default: return FRAME_BITS'($urandom);
    endcase
  endfunction

  // Result side: a random stall before each result, with stretches
  // where stalling is off entirely.
  initial begin
    int  stall;
    int  stretch;
    bit  stalls_on;
    stretch   = 0;
    stalls_on = 1'b1;
    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stretch == 0) begin
        stalls_on = ($urandom_range(0, 2) != 0);
        stretch   = $urandom_range(10, 60);
      end
      stretch--;
      stall = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("frame_playback_sequencer regression: fail");
    $finish;
  end

  initial begin
    int                     goal;
    int                     roll;
    int                     reps;
    logic [FCOUNT_BITS-1:0] fc;
    logic [FRAME_BITS-1:0]  fv;

    sent       = 0;
    counted    = 0;
    cfg_writes = 0;
    idle_on    = 1'b0;
    span_last  = '0;
    cmd_if.valid       <= 1'b0;
    cmd_if.mode        <= MODE_TICK;
    cmd_if.frame_value <= '0;
    cmd_if.speed_value <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.frame_count <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // Default one-frame sequence: stopped tick, then steps that wrap onto 0.
    cmd_op(MODE_TICK);
    cmd_op(MODE_NEXT);
    cmd_op(MODE_PREV);

    load_frame_count(FCOUNT_BITS'(6));
    // Reset interval is 1000 ms even though speed index 10 maps to 200 ms;
    // no speed command has run yet, so one event lands on the 1000th tick.
    cmd_op(MODE_PLAY_FWD);
    repeat (TICKS_PER_SECOND) cmd_op(MODE_TICK);
    cmd_op(MODE_STOP);
    cmd_op(MODE_TICK);                 // stopped: no count
    set_frame('0);
    cmd_op(MODE_PREV);                 // wrap 0 -> last
    cmd_op(MODE_NEXT);                 // wrap last -> 0
    set_frame(span_last);
    set_frame(span_last);              // same frame: no event
    set_frame('1);                     // past the end -> 0
    set_frame('1);                     // past the end while at 0: event, frame stays 0
    set_frame('0);                     // same frame: no event
    set_speed('1);                     // out of range, ignored
    set_speed(SPEED_LAST);
    cmd_op(MODE_FASTER);               // saturated at top
    set_speed('0);
    cmd_op(MODE_SLOWER);               // saturated at bottom
    set_speed(SPEED_BITS'(NUM_SPEEDS)); // first ignored index
    cmd_op(MODE_FASTER);               // 0 -> 1 and starts playback
    cmd_op(SPARE_MODE_LO);
    cmd_op(SPARE_MODE_HI);
    set_speed(SPEED_LAST);
    cmd_op(MODE_PLAY_REV);
    repeat (16) cmd_op(MODE_TICK);     // one backward step at the fastest rate
    cmd_op(MODE_STOP);

    // --- random, one phase per frame_count setting ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: fc = '0;                                  // zero acts as one frame
        1: fc = FCOUNT_BITS'(2);
        2: fc = FCOUNT_BITS'(1) << FRAME_BITS;        // last frame = all ones
        3: fc = '1;                                  // beyond frame width
        4: fc = FCOUNT_BITS'(1);
        5: fc = FCOUNT_BITS'(37);
        6: fc = FCOUNT_BITS'($urandom_range(3, 5000));
        default: fc = FCOUNT_BITS'($urandom);
      endcase
      load_frame_count(fc);
      goal = counted + RANDOM_PER_PHASE;
      while (counted < goal) begin
        idle_on = ($urandom_range(0, 3) != 0);
        roll    = $urandom_range(0, 99);
        if (roll < 40) begin
          // timed playback at a fast rate, a few stray commands mixed in
          set_speed(SPEED_BITS'($urandom_range(12, NUM_SPEEDS - 1)));
          cmd_op($urandom_range(0, 1) ? MODE_PLAY_REV : MODE_PLAY_FWD);
          reps = $urandom_range(10, 70);
          for (int i = 0; i < reps; i++) begin
            if ($urandom_range(0, 9) == 0)
              cmd_op(4'($urandom_range(MODE_TICK, MODE_SET_SPEED)));
            else
              cmd_op(MODE_TICK);
          end
        end else if (roll < 55) begin
          // manual stepping from a frame weighted toward the edges
          set_frame(pick_frame());
          reps = $urandom_range(1, 4);
          repeat (reps) cmd_op($urandom_range(0, 1) ? MODE_PREV : MODE_NEXT);
        end else if (roll < 68) begin
          fv = pick_frame();
          set_frame(fv);
          set_frame(fv);
          if (span_last != '1)
            set_frame(FRAME_BITS'($urandom_range(int'(span_last) + 1,
                                                 (1 << FRAME_BITS) - 1)));
        end else if (roll < 78) begin
          reps = $urandom_range(1, 5);
          repeat (reps) cmd_op($urandom_range(0, 1) ? MODE_SLOWER : MODE_FASTER);
          set_speed(SPEED_BITS'($urandom_range(0, (1 << SPEED_BITS) - 1)));
        end else if (roll < 88) begin
          // noise, spare modes included
          reps = $urandom_range(1, 6);
          repeat (reps) cmd_op(4'($urandom_range(MODE_TICK, SPARE_MODE_HI)));
        end else if (roll < 92) begin
          // slower table entries need long tick runs to fire
          set_speed(SPEED_BITS'($urandom_range(RESET_SPEED, RESET_SPEED + 1)));
          cmd_op($urandom_range(0, 1) ? MODE_PLAY_REV : MODE_PLAY_FWD);
          reps = $urandom_range(100, 210);
          repeat (reps) cmd_op(MODE_TICK);
        end else begin
          cmd_op(MODE_STOP);
          reps = $urandom_range(1, 5);
          repeat (reps) cmd_op(MODE_TICK);
          cmd_op($urandom_range(0, 1) ? MODE_PREV : MODE_NEXT);
        end
      end
    end

    // --- drain and verdict ---
    cmd_if.valid <= 1'b0;
    while (results_seen < sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests (%0d commands) over %0d frame_count writes.",
             sent, counted, cfg_writes);
    $display("Checked %0d results, %0d carrying a frame event.", results_seen, events_seen);
    if (fail_count == 0 && backlog == 0) begin
      $display("frame_playback_sequencer regression: pass");
    end else begin
      $display("frame_playback_sequencer regression: fail");
    end
    $finish;
  end

endmodule
